// File: hdl/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
// No dependencies; imported by sdf_seen_ram and stream_duplicate_filter.
`default_nettype none

package sdf_pkg;

   // Width of one stream value
   localparam int unsigned DATA_W = 32;

   typedef logic signed [DATA_W-1:0] value_type;

endpackage : sdf_pkg

`default_nettype wire

// File: hdl/sdf_seen_ram.sv
// Simple dual-port synchronous RAM that holds the values seen in the current set.
// One write and one read per cycle, read data registered. Depends on sdf_pkg.
`default_nettype none

module sdf_seen_ram #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire sdf_pkg::value_type  wr_data,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output sdf_pkg::value_type       rd_data
);
   import sdf_pkg::*;

   value_type mem_ff [DEPTH];
   value_type rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : sdf_seen_ram

`default_nettype wire

// File: hdl/stream_duplicate_filter.sv
// Passes the first occurrence of each value in a set; repeats of stored values are dropped.
// Flow: after the input transfer the stored entries are read one by one and compared;
// a repeat ends the scan and is dropped, else the emit step registers the result.
// One item at a time: the next input is taken only once the last item is through,
// and the emit step stalls while a held result is not yet taken.
// Reset: synchronous, clears the entry count and control; no RAM clearing pass.
// Depends on sdf_pkg and sdf_seen_ram.
`default_nettype none

module stream_duplicate_filter #(
   parameter int unsigned MAX_DISTINCT = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Input stream
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [31:0]         req_tdata,   // [31:0] value
   input  wire logic                req_tuser,   // [0] new_set
   // Result stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [31:0]              rsp_tdata,   // [31:0] unique_value
   output logic                     rsp_tuser    // [0] not_remembered
);
   import sdf_pkg::*;

   localparam int unsigned IDX_W = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_DISTINCT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DISTINCT);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   value_type         value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff, rsp_value_in;
   logic              rsp_full_ff, rsp_full_in;

   logic              req_xfer;
   logic              out_free;
   logic              store_full;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   value_type         ram_rd_data;
   logic [CNT_W-1:0]  count_eff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign store_full = (count_ff >= CNT_MAX);
   assign count_eff  = req_tuser ? '0 : count_ff;

   // Seen store
   sdf_seen_ram #(
      .DEPTH  (MAX_DISTINCT),
      .ADDR_W (IDX_W)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (value_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Scan sequencer: read, compare, then emit and, while the store has room, append
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_full_in  = rsp_full_ff;
      ram_wr_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               value_in  = value_type'(req_tdata);
               count_in  = count_eff;
               rd_idx_in = CNT_W'(1);
               // entry 0 is read now; an empty store skips the scan
               state_in  = (count_eff == '0) ? S_EMIT : S_SCAN;
            end
         end
         S_SCAN: begin
            if (ram_rd_data == value_ff) begin
               state_in = S_IDLE;
            end else if (rd_idx_ff < count_ff) begin
               ram_rd_addr = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_full_in  = store_full;
               if (!store_full) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 32'(rsp_value_ff);
   assign rsp_tuser  = rsp_full_ff;

`ifndef SYNTHESIS
   // A new result only comes out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) ##1 rsp_valid_ff |-> $past(state_ff == S_EMIT))
      else $error("result appeared without an emit step");

   // Entry count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("seen count exceeds store depth");

   // Scan never reads past the stored entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rd_idx_ff <= count_ff) && (count_ff != '0))
      else $error("scan index beyond stored entries");
`endif

endmodule : stream_duplicate_filter

`default_nettype wire
